>>> rtl/core/wmhs_pkg.sv
package wmhs_pkg;

	// frame classes of the result record
	localparam logic [2:0] ClsUnknown   = 3'd0;
	localparam logic [2:0] ClsBeacon    = 3'd1;
	localparam logic [2:0] ClsProbeReq  = 3'd2;
	localparam logic [2:0] ClsProbeResp = 3'd3;
	localparam logic [2:0] ClsAction    = 3'd4;
	localparam logic [2:0] ClsMgmtOther = 3'd5;
	localparam logic [2:0] ClsControl   = 3'd6;
	localparam logic [2:0] ClsData      = 3'd7;

	// frame control type field
	localparam logic [1:0] KindMgmt    = 2'd0;
	localparam logic [1:0] KindControl = 2'd1;
	localparam logic [1:0] KindData    = 2'd2;
	localparam logic [1:0] KindExt     = 2'd3;

	// management subtypes of interest
	localparam logic [3:0] SubBeacon    = 4'd8;
	localparam logic [3:0] SubProbeReq  = 4'd4;
	localparam logic [3:0] SubProbeResp = 4'd5;
	localparam logic [3:0] SubAction    = 4'd13;

	// band codes
	localparam logic [1:0] BandNone = 2'd0;
	localparam logic [1:0] Band24   = 2'd1;
	localparam logic [1:0] Band5    = 2'd2;
	localparam logic [1:0] Band6    = 2'd3;

	// band edges and channel bases in MHz
	localparam logic [15:0] Freq24Lo   = 16'd2400;
	localparam logic [15:0] Freq24Base = 16'd2407;
	localparam logic [15:0] Freq24Hi   = 16'd2484;
	localparam logic [15:0] Freq5Lo    = 16'd5150;
	localparam logic [15:0] Freq5Base  = 16'd5000;
	localparam logic [15:0] Freq5Hi    = 16'd5895;
	localparam logic [15:0] Freq6Lo    = 16'd5925;
	localparam logic [15:0] Freq6Base  = 16'd5950;
	localparam logic [15:0] Freq6Hi   = 16'd7125;
	localparam logic [7:0]  ChanJapan  = 8'd14;

	// divide by 5 as multiply by ceil(2^16/5) then shift, exact for offsets below 2048
	localparam int          DiffW    = 11;
	localparam logic [13:0] Div5Mul  = 14'd13108;
	localparam int          Div5Shift = 16;

	// signal scaling limits, half-dB units
	localparam logic signed [9:0] RcpiOffset = 10'sd220;
	localparam logic signed [9:0] RcpiMax    = 10'sd220;
	localparam logic signed [9:0] RsniMax    = 10'sd255;

	// byte positions within the header
	localparam logic [4:0] PosFc0     = 5'd0;
	localparam logic [4:0] PosFc1     = 5'd1;
	localparam logic [4:0] PosAddr1Lo = 5'd4;
	localparam logic [4:0] PosAddr1Hi = 5'd9;
	localparam logic [4:0] PosAddr2Lo = 5'd10;
	localparam logic [4:0] PosAddr2Hi = 5'd15;
	localparam logic [4:0] PosAddr3Lo = 5'd16;
	localparam logic [4:0] PosAddr3Hi = 5'd21;
	localparam logic [4:0] PosActLo   = 5'd24;
	localparam logic [4:0] PosActHi   = 5'd26;
	localparam logic [4:0] PosMax     = 5'd31;

	// frame snapshot handed from capture to record build
	typedef struct packed {
		logic [15:0] ctrl;
		logic [47:0] addr1;
		logic [47:0] addr2;
		logic [47:0] addr3;
		logic [23:0] act;
		logic [15:0] freq;
		logic [8:0]  sig;
		logic [8:0]  noise;
		logic        len_ge2;
		logic        len_ge22;
		logic        len_ge27;
	} snap_t;

endpackage

>>> rtl/core/wifi_mac_header_sniffer_top.sv
// 802.11 mac header sniffer: one frame word (byte) per cycle, one record per frame
// after the last word is accepted, the record passes the snapshot, stage 2 and output registers in turn
// throughput: one word per cycle sustained; frames may follow back to back
// input stalls only while a finished record is still held in the capture stage
// reset: arst_n asynchronous active low, clears position count and valid flags
module wifi_mac_header_sniffer_top import wmhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel, frequency and levels sampled on the first word of a frame
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	input  logic [15:0] channel_freq,
	input  logic [8:0]  signal_half_db,
	input  logic [8:0]  noise_half_db,
	// record channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  frame_class,
	output logic [3:0]  sub_type,
	output logic [1:0]  ds_bits,
	output logic [47:0] first_address,
	output logic [47:0] second_address,
	output logic [47:0] third_address,
	output logic [23:0] action_fields,
	output logic [1:0]  present_flags,
	output logic [7:0]  channel_number,
	output logic [1:0]  band_code,
	output logic [7:0]  rcpi_value,
	output logic [7:0]  rsni_value
);

	// snapshot of a completed frame, handed between the two parts
	logic  valid_s1;
	logic  take_s1;
	snap_t snap_s1;

	// position counter and header field capture; loads a snapshot on the last word
	wmhs_frame_capture u_capture (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frame_byte     (frame_byte),
		.last_byte      (last_byte),
		.channel_freq   (channel_freq),
		.signal_half_db (signal_half_db),
		.noise_half_db  (noise_half_db),
		.take_s1        (take_s1),
		.valid_s1       (valid_s1),
		.snap_s1        (snap_s1)
	);

	// frame class decode, band and channel, rcpi/rsni clamps, then output register
	wmhs_record_build u_build (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.snap_s1        (snap_s1),
		.take_s1        (take_s1),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_class    (frame_class),
		.sub_type       (sub_type),
		.ds_bits        (ds_bits),
		.first_address  (first_address),
		.second_address (second_address),
		.third_address  (third_address),
		.action_fields  (action_fields),
		.present_flags  (present_flags),
		.channel_number (channel_number),
		.band_code      (band_code),
		.rcpi_value     (rcpi_value),
		.rsni_value     (rsni_value)
	);

endmodule

>>> rtl/core/wmhs_frame_capture.sv
module wmhs_frame_capture import wmhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	input  logic [15:0] channel_freq,
	input  logic [8:0]  signal_half_db,
	input  logic [8:0]  noise_half_db,
	input  logic        take_s1,
	output logic        valid_s1,
	output snap_t       snap_s1
);

	logic [4:0]  pos_q;
	logic [15:0] ctrl_q;
	logic [47:0] addr1_q, addr2_q, addr3_q;
	logic [23:0] act_q;
	logic [15:0] freq_q;
	logic [8:0]  sig_q, noise_q;

	logic        accept;
	logic        first;
	logic [15:0] ctrl_n;
	logic [47:0] addr1_n, addr2_n, addr3_n;
	logic [23:0] act_n;
	logic [15:0] freq_n;
	logic [8:0]  sig_n, noise_n;
	logic [4:0]  pos_n;

	assign in_stall = valid_s1 && !take_s1;
	assign accept   = in_valid && !in_stall;
	assign first    = (pos_q == PosFc0);

	// next state after folding in the current byte; first byte clears the frame
	always_comb begin
		ctrl_n  = first ? 16'h0000 : ctrl_q;
		addr1_n = first ? 48'h0 : addr1_q;
		addr2_n = first ? 48'h0 : addr2_q;
		addr3_n = first ? 48'h0 : addr3_q;
		act_n   = first ? 24'h0 : act_q;
		freq_n  = first ? channel_freq : freq_q;
		sig_n   = first ? signal_half_db : sig_q;
		noise_n = first ? noise_half_db : noise_q;
		if (pos_q == PosFc0) begin
			ctrl_n = {8'h00, frame_byte};
		end else if (pos_q == PosFc1) begin
			ctrl_n = {frame_byte, ctrl_q[7:0]};
		end
		if (pos_q >= PosAddr1Lo && pos_q <= PosAddr1Hi) begin
			addr1_n = {addr1_q[39:0], frame_byte};
		end
		if (pos_q >= PosAddr2Lo && pos_q <= PosAddr2Hi) begin
			addr2_n = {addr2_q[39:0], frame_byte};
		end
		if (pos_q >= PosAddr3Lo && pos_q <= PosAddr3Hi) begin
			addr3_n = {addr3_q[39:0], frame_byte};
		end
		if (pos_q >= PosActLo && pos_q <= PosActHi) begin
			act_n = {act_q[15:0], frame_byte};
		end
		if (last_byte) begin
			pos_n = PosFc0;
		end else if (pos_q != PosMax) begin
			pos_n = pos_q + 5'd1;
		end else begin
			pos_n = pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= PosFc0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= pos_n;
			end
			if (accept && last_byte) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_q  <= ctrl_n;
			addr1_q <= addr1_n;
			addr2_q <= addr2_n;
			addr3_q <= addr3_n;
			act_q   <= act_n;
			freq_q  <= freq_n;
			sig_q   <= sig_n;
			noise_q <= noise_n;
		end
		if (accept && last_byte) begin
			snap_s1.ctrl     <= ctrl_n;
			snap_s1.addr1    <= addr1_n;
			snap_s1.addr2    <= addr2_n;
			snap_s1.addr3    <= addr3_n;
			snap_s1.act      <= act_n;
			snap_s1.freq     <= freq_n;
			snap_s1.sig      <= sig_n;
			snap_s1.noise    <= noise_n;
			snap_s1.len_ge2  <= (pos_q >= PosFc1);
			snap_s1.len_ge22 <= (pos_q >= PosAddr3Hi);
			snap_s1.len_ge27 <= (pos_q >= PosActHi);
		end
	end

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (pos_q == PosFc0))
		else $error("byte position not cleared after last word");

	a_snap_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> valid_s1)
		else $error("last word did not load a snapshot");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && !take_s1))
		else $error("input stalled with free snapshot stage");

endmodule

>>> rtl/core/wmhs_record_build.sv
module wmhs_record_build import wmhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  snap_t       snap_s1,
	output logic        take_s1,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  frame_class,
	output logic [3:0]  sub_type,
	output logic [1:0]  ds_bits,
	output logic [47:0] first_address,
	output logic [47:0] second_address,
	output logic [47:0] third_address,
	output logic [23:0] action_fields,
	output logic [1:0]  present_flags,
	output logic [7:0]  channel_number,
	output logic [1:0]  band_code,
	output logic [7:0]  rcpi_value,
	output logic [7:0]  rsni_value
);

	// stage 2: decoded record, channel offset not yet divided
	logic             valid_s2;
	logic [2:0]       cls_s2;
	logic [3:0]       sub_s2;
	logic [1:0]       ds_s2;
	logic [47:0]      addr1_s2, addr2_s2, addr3_s2;
	logic [23:0]      act_s2;
	logic [1:0]       flags_s2;
	logic [1:0]       band_s2;
	logic [DiffW-1:0] diff_s2;
	logic             div_s2;
	logic [7:0]       chan_fix_s2;
	logic [7:0]       rcpi_s2, rsni_s2;

	logic             out_free, s2_free;

	logic [2:0]       cls_c;
	logic [3:0]       sub_c;
	logic [1:0]       ds_c;
	logic             addr_ok, act_ok;
	logic [1:0]       band_c;
	logic [15:0]      diff_c;
	logic             div_c;
	logic [7:0]       chan_fix_c;
	logic signed [9:0] sig_x, noise_x, rcpi_sum, rsni_sum;
	logic [7:0]       rcpi_c, rsni_c;
	logic [24:0]      prod;

	assign out_free = !out_valid || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign take_s1  = valid_s1 && s2_free;

	// frame control decode
	always_comb begin
		cls_c = ClsUnknown;
		sub_c = 4'd0;
		ds_c  = 2'd0;
		if (snap_s1.len_ge2) begin
			sub_c = snap_s1.ctrl[7:4];
			ds_c  = snap_s1.ctrl[9:8];
			unique case (snap_s1.ctrl[3:2])
				KindMgmt: begin
					priority if (sub_c == SubBeacon)    cls_c = ClsBeacon;
					else if (sub_c == SubProbeReq)      cls_c = ClsProbeReq;
					else if (sub_c == SubProbeResp)     cls_c = ClsProbeResp;
					else if (sub_c == SubAction)        cls_c = ClsAction;
					else                                cls_c = ClsMgmtOther;
				end
				KindControl: cls_c = ClsControl;
				KindData:    cls_c = ClsData;
				KindExt:     cls_c = ClsUnknown;
			endcase
		end
		addr_ok = snap_s1.len_ge22;
		act_ok  = (cls_c == ClsAction) && snap_s1.len_ge27;
	end

	// band select and channel offset
	always_comb begin
		band_c     = BandNone;
		diff_c     = 16'd0;
		div_c      = 1'b0;
		chan_fix_c = 8'd0;
		priority if (snap_s1.freq >= Freq24Lo && snap_s1.freq <= Freq24Hi) begin
			band_c = Band24;
			if (snap_s1.freq == Freq24Hi) begin
				chan_fix_c = ChanJapan;
			end else if (snap_s1.freq >= Freq24Base) begin
				div_c  = 1'b1;
				diff_c = snap_s1.freq - Freq24Base;
			end
		end else if (snap_s1.freq >= Freq5Lo && snap_s1.freq <= Freq5Hi) begin
			band_c = Band5;
			div_c  = 1'b1;
			diff_c = snap_s1.freq - Freq5Base;
		end else if (snap_s1.freq >= Freq6Lo && snap_s1.freq <= Freq6Hi) begin
			band_c = Band6;
			if (snap_s1.freq >= Freq6Base) begin
				div_c  = 1'b1;
				diff_c = snap_s1.freq - Freq6Base;
			end
		end else begin
			band_c = BandNone;
		end
	end

	// rcpi and rsni with clamping
	always_comb begin
		sig_x    = $signed({snap_s1.sig[8], snap_s1.sig});
		noise_x  = $signed({snap_s1.noise[8], snap_s1.noise});
		rcpi_sum = sig_x + RcpiOffset;
		rsni_sum = sig_x - noise_x;
		priority if (rcpi_sum < 10'sd0)  rcpi_c = 8'd0;
		else if (rcpi_sum > RcpiMax)     rcpi_c = RcpiMax[7:0];
		else                             rcpi_c = rcpi_sum[7:0];
		priority if (rsni_sum < 10'sd0)  rsni_c = 8'd0;
		else if (rsni_sum > RsniMax)     rsni_c = RsniMax[7:0];
		else                             rsni_c = rsni_sum[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			cls_s2      <= cls_c;
			sub_s2      <= sub_c;
			ds_s2       <= ds_c;
			addr1_s2    <= addr_ok ? snap_s1.addr1 : 48'h0;
			addr2_s2    <= addr_ok ? snap_s1.addr2 : 48'h0;
			addr3_s2    <= addr_ok ? snap_s1.addr3 : 48'h0;
			act_s2      <= act_ok ? snap_s1.act : 24'h0;
			flags_s2    <= {act_ok, addr_ok};
			band_s2     <= band_c;
			diff_s2     <= diff_c[DiffW-1:0];
			div_s2      <= div_c;
			chan_fix_s2 <= chan_fix_c;
			rcpi_s2     <= rcpi_c;
			rsni_s2     <= rsni_c;
		end
	end

	// offset / 5 by reciprocal multiply
	assign prod = 25'(diff_s2) * 25'(Div5Mul);

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			frame_class    <= cls_s2;
			sub_type       <= sub_s2;
			ds_bits        <= ds_s2;
			first_address  <= addr1_s2;
			second_address <= addr2_s2;
			third_address  <= addr3_s2;
			action_fields  <= act_s2;
			present_flags  <= flags_s2;
			channel_number <= div_s2 ? prod[Div5Shift+7:Div5Shift] : chan_fix_s2;
			band_code      <= band_s2;
			rcpi_value     <= rcpi_s2;
			rsni_value     <= rsni_s2;
		end
	end

	a_rcpi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rcpi_value <= RcpiMax[7:0]))
		else $error("rcpi above ceiling");

	a_action_class: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && present_flags[1]) |-> (frame_class == ClsAction))
		else $error("action fields flagged on non-action frame");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !present_flags[0]) |->
		(first_address == 48'h0 && second_address == 48'h0 && third_address == 48'h0))
		else $error("absent addresses not zero");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import wmhs_pkg::*;

	// run shape
	localparam int RandomWords = 1530;
	localparam int HoldAtWord  = 700;
	localparam int HoldCycles  = 400;
	localparam int CycleLimit  = 200000;

	// one byte of a frame as offered on the byte channel
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [15:0] freq;
		logic [8:0]  sig;
		logic [8:0]  noise;
		logic        drain;
	} frame_word_t;

	// one header record as seen on the record channel
	typedef struct packed {
		logic [2:0]  frame_class;
		logic [3:0]  sub_type;
		logic [1:0]  ds_bits;
		logic [47:0] addr1;
		logic [47:0] addr2;
		logic [47:0] addr3;
		logic [23:0] act;
		logic [1:0]  flags;
		logic [7:0]  chan;
		logic [1:0]  band;
		logic [7:0]  rcpi;
		logic [7:0]  rsni;
	} header_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall = 1'b0;
	frame_word_t cur_word = '0;
	header_rec_t dut_rec;

	logic [7:0]  frame_byte;
	logic        last_byte;
	logic [15:0] channel_freq;
	logic [8:0]  signal_half_db;
	logic [8:0]  noise_half_db;

	// payload ports all come from the current word
	assign frame_byte     = cur_word.data;
	assign last_byte      = cur_word.last;
	assign channel_freq   = cur_word.freq;
	assign signal_half_db = cur_word.sig;
	assign noise_half_db  = cur_word.noise;

	wifi_mac_header_sniffer_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frame_byte     (frame_byte),
		.last_byte      (last_byte),
		.channel_freq   (channel_freq),
		.signal_half_db (signal_half_db),
		.noise_half_db  (noise_half_db),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_class    (dut_rec.frame_class),
		.sub_type       (dut_rec.sub_type),
		.ds_bits        (dut_rec.ds_bits),
		.first_address  (dut_rec.addr1),
		.second_address (dut_rec.addr2),
		.third_address  (dut_rec.addr3),
		.action_fields  (dut_rec.act),
		.present_flags  (dut_rec.flags),
		.channel_number (dut_rec.chan),
		.band_code      (dut_rec.band),
		.rcpi_value     (dut_rec.rcpi),
		.rsni_value     (dut_rec.rsni)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// words waiting to be driven, records waiting to come out
	frame_word_t frame_words[$];
	header_rec_t pending_records[$];

	int  errors = 0;
	int  cycle_cnt = 0;
	int  words_in = 0;
	bit  word_taken = 1'b0;
	bit  hold_on = 1'b0;

	// header parser shadow state
	logic [4:0]  hdr_pos = '0;
	logic [15:0] fc_bytes = '0;
	logic [47:0] addr_bytes [3] = '{default: '0};
	logic [23:0] act_bytes = '0;
	logic [15:0] held_freq = '0;
	logic [8:0]  held_sig = '0;
	logic [8:0]  held_noise = '0;

	// band edges and holes, hit often by the random frames
	logic [15:0] freq_edges [20] = '{16'd0, 16'd2399, 16'd2400, 16'd2406, 16'd2407,
		16'd2483, 16'd2484, 16'd2485, 16'd5149, 16'd5150, 16'd5895, 16'd5896,
		16'd5924, 16'd5925, 16'd5949, 16'd5950, 16'd7125, 16'd7126, 16'd32768,
		16'd65535};

	// advance the header parser by one byte; returns 1 when a record is due
	function automatic bit parse_header_byte(input frame_word_t w, output header_rec_t rec);
		logic [4:0] p;
		logic [1:0] kind;
		logic [3:0] sub;
		int len, k, f, s, n, rcpi, rsni;
		p = hdr_pos;
		rec = '0;
		// first word of a frame: sample radio levels, clear captures
		if (p == PosFc0) begin
			held_freq  = w.freq;
			held_sig   = w.sig;
			held_noise = w.noise;
			fc_bytes   = '0;
			addr_bytes = '{default: '0};
			act_bytes  = '0;
		end
		if (p == PosFc0)
			fc_bytes[7:0] = w.data;
		else if (p == PosFc1)
			fc_bytes[15:8] = w.data;
		else if (p >= PosAddr1Lo && p <= PosAddr3Hi) begin
			k = (int'(p) - int'(PosAddr1Lo)) / 6;
			addr_bytes[k] = {addr_bytes[k][39:0], w.data};
		end else if (p >= PosActLo && p <= PosActHi)
			act_bytes = {act_bytes[15:0], w.data};
		// position saturates, later bytes are ignored
		if (p != PosMax)
			hdr_pos = p + 5'd1;
		if (!w.last)
			return 1'b0;

		len = int'(p) + 1;
		if (len >= 2) begin
			kind = fc_bytes[3:2];
			sub  = fc_bytes[7:4];
			case (kind)
				KindMgmt: begin
					case (sub)
						SubBeacon:    rec.frame_class = ClsBeacon;
						SubProbeReq:  rec.frame_class = ClsProbeReq;
						SubProbeResp: rec.frame_class = ClsProbeResp;
						SubAction:    rec.frame_class = ClsAction;
						default:      rec.frame_class = ClsMgmtOther;
					endcase
				end
				KindControl: rec.frame_class = ClsControl;
				KindData:    rec.frame_class = ClsData;
				default:     rec.frame_class = ClsUnknown;
			endcase
			rec.sub_type = sub;
			rec.ds_bits  = fc_bytes[9:8];
		end
		if (len >= 22) begin
			rec.addr1 = addr_bytes[0];
			rec.addr2 = addr_bytes[1];
			rec.addr3 = addr_bytes[2];
			rec.flags[0] = 1'b1;
		end
		if (rec.frame_class == ClsAction && len >= 27) begin
			rec.act = act_bytes;
			rec.flags[1] = 1'b1;
		end

		// channel and band; negative channels at the low edges become 0
		f = int'(held_freq);
		rec.band = BandNone;
		rec.chan = '0;
		if (f >= int'(Freq24Lo) && f <= int'(Freq24Hi)) begin
			rec.band = Band24;
			if (f == int'(Freq24Hi))
				rec.chan = ChanJapan;
			else if (f >= int'(Freq24Base))
				rec.chan = 8'((f - int'(Freq24Base)) / 5);
		end else if (f >= int'(Freq5Lo) && f <= int'(Freq5Hi)) begin
			rec.band = Band5;
			rec.chan = 8'((f - int'(Freq5Base)) / 5);
		end else if (f >= int'(Freq6Lo) && f <= int'(Freq6Hi)) begin
			rec.band = Band6;
			if (f >= int'(Freq6Base))
				rec.chan = 8'((f - int'(Freq6Base)) / 5);
		end

		// levels in half-dB, so both scalings are exact
		s = int'($signed(held_sig));
		n = int'($signed(held_noise));
		rcpi = s + 220;
		if (rcpi < 0) rcpi = 0;
		if (rcpi > 220) rcpi = 220;
		rsni = s - n;
		if (rsni < 0) rsni = 0;
		if (rsni > 255) rsni = 255;
		rec.rcpi = 8'(rcpi);
		rec.rsni = 8'(rsni);

		hdr_pos = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_cnt, what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [47:0] got,
			input logic [47:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// append one frame; first two bytes given, the rest random
	task automatic queue_frame(input int len, input logic [7:0] fc0, input logic [7:0] fc1,
			input logic [15:0] freq, input logic [8:0] sig, input logic [8:0] noise,
			input bit drain);
		frame_word_t w;
		for (int i = 0; i < len; i++) begin
			w.data  = (i == 0) ? fc0 : (i == 1) ? fc1 : 8'($urandom);
			w.last  = (i == len - 1);
			// levels only count on the first word; scramble them elsewhere
			w.freq  = (i == 0) ? freq : 16'($urandom);
			w.sig   = (i == 0) ? sig : 9'($urandom);
			w.noise = (i == 0) ? noise : 9'($urandom);
			w.drain = (i == 0) && drain;
			frame_words.push_back(w);
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk) begin
		header_rec_t want;
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end else if (arst_n) begin
			word_taken = in_valid && !in_stall;
			if (word_taken) begin
				words_in++;
				if (parse_header_byte(cur_word, want))
					pending_records.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_records.size() == 0)
					report_mismatch("record with none expected");
				else begin
					want = pending_records.pop_front();
					check_field("frame_class", 48'(dut_rec.frame_class),
						48'(want.frame_class));
					check_field("sub_type", 48'(dut_rec.sub_type), 48'(want.sub_type));
					check_field("ds_bits", 48'(dut_rec.ds_bits), 48'(want.ds_bits));
					check_field("first_address", dut_rec.addr1, want.addr1);
					check_field("second_address", dut_rec.addr2, want.addr2);
					check_field("third_address", dut_rec.addr3, want.addr3);
					check_field("action_fields", 48'(dut_rec.act), 48'(want.act));
					check_field("present_flags", 48'(dut_rec.flags), 48'(want.flags));
					check_field("channel_number", 48'(dut_rec.chan), 48'(want.chan));
					check_field("band_code", 48'(dut_rec.band), 48'(want.band));
					check_field("rcpi_value", 48'(dut_rec.rcpi), 48'(want.rcpi));
					check_field("rsni_value", 48'(dut_rec.rsni), 48'(want.rsni));
				end
			end
		end
	end

	// byte driver: bursts of words with random gaps; a drain mark holds the
	// frame back until every record in flight has come out
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || word_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (frame_words.size() == 0 ||
					(frame_words[0].drain && pending_records.size() != 0))
				in_valid <= 1'b0;
			else begin
				cur_word <= frame_words.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1)
					burst_left--;
				else begin
					// now and then a long unbroken run
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// one long receiver hold-off, so the block backs up into in_stall
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(negedge clk) begin
		if (!hold_done && words_in >= HoldAtWord) begin
			hold_done = 1'b1;
			hold_left = HoldCycles;
		end
		if (hold_left != 0)
			hold_left--;
		hold_on <= (hold_left != 0);
	end

	// record stall: a mode picked at random for a random stretch
	int stall_mode = 0;
	int mode_left = 0;

	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (hold_on)
			out_stall <= 1'b1;
		else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ((cycle_cnt % 5) < 2);
				default: out_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// stimulus and end of run
	initial begin
		int words, frames, len, pick;
		logic [7:0]  fc0;
		logic [15:0] freq;

		// directed: every class, each length threshold, band edges, level extremes
		queue_frame(1, 8'hFF, 8'h00, 16'd0, 9'h100, 9'h0FF, 1'b0);
		queue_frame(2, {SubBeacon, KindMgmt, 2'b00}, 8'h03, 16'd2400, 9'h0FF, 9'h100, 1'b0);
		queue_frame(2, {SubProbeReq, KindMgmt, 2'b11}, 8'h01, 16'd2406, 9'h124, 9'h000, 1'b0);
		queue_frame(2, {SubProbeResp, KindMgmt, 2'b00}, 8'h02, 16'd2407, 9'h123, 9'h000, 1'b0);
		queue_frame(2, {SubAction, KindMgmt, 2'b00}, 8'hFC, 16'd2484, 9'h000, 9'h000, 1'b0);
		queue_frame(2, {4'd0, KindMgmt, 2'b00}, 8'h00, 16'd2485, 9'h001, 9'h1FF, 1'b0);
		queue_frame(2, {4'd4, KindControl, 2'b00}, 8'hFF, 16'd5150, 9'h07F, 9'h180, 1'b0);
		queue_frame(2, {4'd8, KindData, 2'b00}, 8'h02, 16'd5895, 9'h1FF, 9'h000, 1'b0);
		queue_frame(2, {4'd15, KindExt, 2'b00}, 8'h01, 16'd5925, 9'h000, 9'h001, 1'b0);
		queue_frame(21, {SubAction, KindMgmt, 2'b00}, 8'h00, 16'd5949, 9'h050, 9'h1A0, 1'b0);
		queue_frame(22, {4'd0, KindData, 2'b00}, 8'h03, 16'd5950, 9'h1C0, 9'h180, 1'b1);
		queue_frame(26, {SubAction, KindMgmt, 2'b00}, 8'h00, 16'd7125, 9'h010, 9'h020, 1'b0);
		queue_frame(27, {SubAction, KindMgmt, 2'b00}, 8'h00, 16'd7126, 9'h100, 9'h100, 1'b0);
		queue_frame(40, {SubAction, KindMgmt, 2'b01}, 8'h01, 16'hFFFF, 9'h0FF, 9'h0FF, 1'b0);
		queue_frame(31, {SubBeacon, KindMgmt, 2'b00}, 8'h02, 16'd5896, 9'h0DC, 9'h1E0, 1'b0);
		queue_frame(32, {SubAction, KindMgmt, 2'b00}, 8'h00, 16'd5924, 9'h122, 9'h121, 1'b0);

		// random frames, mostly full headers with random content
		words = 0;
		frames = 0;
		while (words < RandomWords) begin
			pick = $urandom_range(0, 9);
			if (pick < 2)
				len = $urandom_range(1, 3);
			else if (pick < 4)
				len = $urandom_range(4, 21);
			else if (pick < 9)
				len = $urandom_range(22, 30);
			else
				len = $urandom_range(31, 45);

			pick = $urandom_range(0, 5);
			if (pick < 2)
				fc0 = {SubAction, KindMgmt, 2'($urandom)};
			else if (pick == 2)
				fc0 = {4'($urandom), KindMgmt, 2'($urandom)};
			else
				fc0 = 8'($urandom);

			pick = $urandom_range(0, 9);
			if (pick < 2)
				freq = 16'($urandom);
			else if (pick < 4)
				freq = freq_edges[$urandom_range(0, 19)];
			else if (pick < 6)
				freq = 16'($urandom_range(2400, 2484));
			else if (pick < 8)
				freq = 16'($urandom_range(5150, 5895));
			else
				freq = 16'($urandom_range(5925, 7125));

			// every so often the sender waits for the block to drain
			queue_frame(len, fc0, 8'($urandom), freq, 9'($urandom), 9'($urandom),
				(frames % 25) == 12);
			words += len;
			frames++;
		end

		// hold reset, then release it off the active edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all words accepted, all records out, then a short settle
		while (frame_words.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/wmhs_pkg.sv
rtl/core/wmhs_frame_capture.sv
rtl/core/wmhs_record_build.sv
rtl/core/wifi_mac_header_sniffer_top.sv
tb/testbench.sv
